### rtl/fcb_pkg.sv
// Shared types and constants for the frustum box cull block.
package fcb_pkg;

    localparam int NUM_PLANES  = 6;
    localparam int FLAT_PLANES = 4;
    localparam int PLANE_W     = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int COEF_W      = 16;
    localparam int D_SHIFT     = 14;
    localparam int AXES        = 3;
    localparam int BOX_N       = 2 * AXES;

    typedef enum logic [1:0] {
        ST_OUTSIDE   = 2'd0,
        ST_INSIDE    = 2'd1,
        ST_INTERSECT = 2'd2
    } fcb_status_t;

    typedef struct packed {
        logic valid;
        logic flat;
        logic outside;
        logic all_in;
    } fcb_tag_t;

endpackage

### rtl/fcb_cell.sv
// One plane cell: holds a plane, tests the passing box and hands it on.
module fcb_cell
    import fcb_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 load,
    input  logic [PLANE_W-1:0]                   load_data,
    input  logic                                 use_in_flat,
    input  fcb_tag_t                             tag_in,
    input  logic [BOX_N-1:0][COORD_BITS-1:0]     box_in,
    output fcb_tag_t                             tag_out,
    output logic [BOX_N-1:0][COORD_BITS-1:0]     box_out
);

    localparam int PROD_W = COEF_W + COORD_BITS;
    localparam int D_W    = COEF_W + D_SHIFT;
    localparam int DOT_W  = ((PROD_W > D_W) ? PROD_W : D_W) + 2;

    logic [PLANE_W-1:0] plane_reg;

    logic signed [COEF_W-1:0]     coef      [AXES];
    logic signed [COORD_BITS-1:0] cmax      [AXES];
    logic signed [COORD_BITS-1:0] cmin      [AXES];
    logic signed [PROD_W-1:0]     pmax_next [AXES];
    logic signed [PROD_W-1:0]     pmin_next [AXES];
    logic signed [PROD_W-1:0]     pmax_reg  [AXES];
    logic signed [PROD_W-1:0]     pmin_reg  [AXES];

    fcb_tag_t                          tag_a_reg;
    logic [BOX_N-1:0][COORD_BITS-1:0]  box_a_reg;

    logic signed [DOT_W-1:0] d_term;
    logic signed [DOT_W-1:0] dot_max;
    logic signed [DOT_W-1:0] dot_min;
    fcb_tag_t                tag_next;
    fcb_tag_t                tag_reg;
    logic [BOX_N-1:0][COORD_BITS-1:0] box_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else if (load)
        begin
            plane_reg <= load_data;
        end
    end

    // pick the corner coordinate that gives the larger and smaller product per axis
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            logic signed [COORD_BITS-1:0] lo;
            logic signed [COORD_BITS-1:0] hi;
            logic                         pick_hi;
            lo           = $signed(box_in[k]);
            hi           = $signed(box_in[k + AXES]);
            coef[k]      = $signed(plane_reg[COEF_W*k +: COEF_W]);
            pick_hi      = (!coef[k][COEF_W-1]) == (hi >= lo);
            cmax[k]      = pick_hi ? hi : lo;
            cmin[k]      = pick_hi ? lo : hi;
            pmax_next[k] = PROD_W'(coef[k]) * PROD_W'(cmax[k]);
            pmin_next[k] = PROD_W'(coef[k]) * PROD_W'(cmin[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
        end
        else if (en)
        begin
            tag_a_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            box_a_reg <= box_in;
            for (int k = 0; k < AXES; k++)
            begin
                pmax_reg[k] <= pmax_next[k];
                pmin_reg[k] <= pmin_next[k];
            end
        end
    end

    always_comb
    begin
        d_term  = DOT_W'($signed(plane_reg[PLANE_W-1 -: COEF_W]));
        d_term  = d_term <<< D_SHIFT;
        dot_max = DOT_W'(pmax_reg[0]) + DOT_W'(pmax_reg[1]) + DOT_W'(pmax_reg[2]) + d_term;
        dot_min = DOT_W'(pmin_reg[0]) + DOT_W'(pmin_reg[1]) + DOT_W'(pmin_reg[2]) + d_term;
        tag_next = tag_a_reg;
        if (tag_a_reg.valid && (!tag_a_reg.flat || use_in_flat))
        begin
            tag_next.outside = tag_a_reg.outside | dot_max[DOT_W-1];
            tag_next.all_in  = tag_a_reg.all_in & !dot_min[DOT_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            box_reg <= box_a_reg;
        end
    end

    assign tag_out = tag_reg;
    assign box_out = box_reg;

endmodule

### rtl/frustum_box_cull.sv
// Top level of the frustum box cull block: plane cell chain and output skid.
// Classifies one axis-aligned box per clock while in_stall is low, against
// six stored planes (the first four in flat mode). Each box walks a chain of
// six plane cells, each with a multiply stage and a sum and sign stage; the
// first of the 12 cell stages loads on the accepting edge and the output
// register follows the last one. Boxes may follow each other in every cycle;
// a stalled result is held in the output register and one more in a skid
// register, and in_stall rises only once that skid register is full. Plane
// registers are written through wr_en, wr_index and wr_data, by the user only
// while no box is in flight (not enforced); indexes 6 and 7 are ignored.
module frustum_box_cull
    import fcb_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [CFG_IDX_W-1:0]         wr_index,
    input  logic [PLANE_W-1:0]           wr_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic signed [COORD_BITS-1:0] min_x,
    input  logic signed [COORD_BITS-1:0] min_y,
    input  logic signed [COORD_BITS-1:0] min_z,
    input  logic signed [COORD_BITS-1:0] max_x,
    input  logic signed [COORD_BITS-1:0] max_y,
    input  logic signed [COORD_BITS-1:0] max_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status
);

    fcb_tag_t                          tag_chain [NUM_PLANES+1];
    logic [BOX_N-1:0][COORD_BITS-1:0]  box_chain [NUM_PLANES+1];
    logic                              en;

    fcb_status_t o_status_reg;
    fcb_status_t o_status_next;
    logic        o_valid_reg;
    logic        o_valid_next;
    fcb_status_t s_status_reg;
    fcb_status_t s_status_next;
    logic        s_valid_reg;
    logic        s_valid_next;
    fcb_status_t result;

    assign en = !s_valid_reg;

    // drop z in flat mode
    always_comb
    begin
        tag_chain[0].valid   = in_valid;
        tag_chain[0].flat    = op;
        tag_chain[0].outside = 1'b0;
        tag_chain[0].all_in  = 1'b1;
        box_chain[0][0] = min_x;
        box_chain[0][1] = min_y;
        box_chain[0][2] = op ? '0 : min_z;
        box_chain[0][3] = max_x;
        box_chain[0][4] = max_y;
        box_chain[0][5] = op ? '0 : max_z;
    end

    for (genvar i = 0; i < NUM_PLANES; i++)
    begin : g_cell
        fcb_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (en),
            .load        (wr_en && (wr_index == CFG_IDX_W'(i))),
            .load_data   (wr_data),
            .use_in_flat (i < FLAT_PLANES),
            .tag_in      (tag_chain[i]),
            .box_in      (box_chain[i]),
            .tag_out     (tag_chain[i+1]),
            .box_out     (box_chain[i+1])
        );
    end

    always_comb
    begin
        priority if (tag_chain[NUM_PLANES].outside)
            result = ST_OUTSIDE;
        else if (tag_chain[NUM_PLANES].all_in)
            result = ST_INSIDE;
        else
            result = ST_INTERSECT;
    end

    always_comb
    begin
        o_valid_next  = o_valid_reg;
        o_status_next = o_status_reg;
        s_valid_next  = s_valid_reg;
        s_status_next = s_status_reg;
        if (s_valid_reg)
        begin
            if (!out_stall)
            begin
                o_status_next = s_status_reg;
                s_valid_next  = 1'b0;
            end
        end
        else if (o_valid_reg && out_stall)
        begin
            if (tag_chain[NUM_PLANES].valid)
            begin
                s_valid_next  = 1'b1;
                s_status_next = result;
            end
        end
        else
        begin
            o_valid_next  = tag_chain[NUM_PLANES].valid;
            o_status_next = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= o_valid_next;
            s_valid_reg <= s_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_status_reg <= o_status_next;
        s_status_reg <= s_status_next;
    end

    assign in_stall  = s_valid_reg;
    assign out_valid = o_valid_reg;
    assign status    = o_status_reg;

endmodule

### rtl/fcb_check.sv
// Port-level assertions for the frustum box cull block, bound to the top level.
module fcb_check
    import fcb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_hold_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OUTSIDE || status == ST_INSIDE || status == ST_INTERSECT))
        else $error("status code out of range");

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall rose without output stall");

endmodule

bind frustum_box_cull fcb_check u_fcb_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status)
);

### tb/sv/frustum_box_cull_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for frustum_box_cull: directed and random boxes against a plane predictor.
module frustum_box_cull_tb;
    import fcb_pkg::*;

    localparam int COORD_BITS   = 16;
    localparam int PIPE_LATENCY = 13;
    localparam int LONG_HOLD    = 80;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int ONE_Q14      = 16384;
    localparam int PHASE_ITEMS  = 200;

    typedef enum logic {
        OP_FULL = 1'b0,
        OP_FLAT = 1'b1
    } box_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        PL_NEAR        = 3'd0,
        PL_FAR         = 3'd1,
        PL_LEFT        = 3'd2,
        PL_RIGHT       = 3'd3,
        PL_TOP         = 3'd4,
        PL_BOTTOM      = 3'd5,
        PL_UNMAPPED_LO = 3'd6,
        PL_UNMAPPED_HI = 3'd7
    } plane_idx_t;

    typedef struct {
        box_op_t                      op;
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] min_z;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] max_y;
        logic signed [COORD_BITS-1:0] max_z;
    } box_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]         wr_index = '0;
    logic [PLANE_W-1:0]           wr_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         op = 1'b0;
    logic signed [COORD_BITS-1:0] min_x = '0;
    logic signed [COORD_BITS-1:0] min_y = '0;
    logic signed [COORD_BITS-1:0] min_z = '0;
    logic signed [COORD_BITS-1:0] max_x = '0;
    logic signed [COORD_BITS-1:0] max_y = '0;
    logic signed [COORD_BITS-1:0] max_z = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [1:0]                   status;

    logic [PLANE_W-1:0] plane_copy [NUM_PLANES];
    logic [PLANE_W-1:0] next_planes [NUM_PLANES];
    fcb_status_t        expected_status [$];
    int                 mismatches = 0;
    int                 cycle_count = 0;
    int                 hold_requests = 0;
    bit                 tx_gaps = 1'b0;
    bit                 rx_jitter = 1'b0;

    frustum_box_cull #(
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .min_x     (min_x),
        .min_y     (min_y),
        .min_z     (min_z),
        .max_x     (max_x),
        .max_y     (max_y),
        .max_z     (max_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint plane_coef(logic [PLANE_W-1:0] pl, int k);
        return longint'($signed(pl[k*COEF_W +: COEF_W]));
    endfunction

    function automatic fcb_status_t classify_box(box_t b);
        longint lo [AXES];
        longint hi [AXES];
        longint ca, cb, cc, cd, dot, cx, cy, cz;
        int     n_planes, n_corners, behind, clear_planes;
        lo[0] = longint'(b.min_x);
        lo[1] = longint'(b.min_y);
        lo[2] = longint'(b.min_z);
        hi[0] = longint'(b.max_x);
        hi[1] = longint'(b.max_y);
        hi[2] = longint'(b.max_z);
        n_planes = NUM_PLANES;
        n_corners = 8;
        if (b.op == OP_FLAT)
        begin
            lo[2] = 0;
            hi[2] = 0;
            n_planes = FLAT_PLANES;
            n_corners = 4;
        end
        clear_planes = 0;
        for (int p = 0; p < n_planes; p++)
        begin
            ca = plane_coef(plane_copy[p], 0);
            cb = plane_coef(plane_copy[p], 1);
            cc = plane_coef(plane_copy[p], 2);
            cd = plane_coef(plane_copy[p], 3) * (longint'(1) << D_SHIFT);
            behind = 0;
            for (int v = 0; v < n_corners; v++)
            begin
                cx = ((v & 1) != 0) ? hi[0] : lo[0];
                cy = ((v & 2) != 0) ? hi[1] : lo[1];
                cz = ((v & 4) != 0) ? hi[2] : lo[2];
                dot = ca * cx + cb * cy + cc * cz + cd;
                if (dot < 0)
                    behind++;
            end
            if (behind == n_corners)
                return ST_OUTSIDE;
            if (behind == 0)
                clear_planes++;
        end
        return (clear_planes == n_planes) ? ST_INSIDE : ST_INTERSECT;
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(int a, int b, int c, int d);
        return {d[COEF_W-1:0], c[COEF_W-1:0], b[COEF_W-1:0], a[COEF_W-1:0]};
    endfunction

    // Plane facing along one axis, with small tilt on the other two.
    function automatic logic [PLANE_W-1:0] facing_plane(int axis, bit flip);
        int coef [AXES];
        int d;
        for (int k = 0; k < AXES; k++)
            coef[k] = int'($urandom_range(0, 4094)) - 2047;
        coef[axis] = int'($urandom_range(4096, 32767));
        if (flip)
            coef[axis] = -coef[axis];
        d = int'($urandom_range(0, 3600)) - 400;
        return pack_plane(coef[0], coef[1], coef[2], d);
    endfunction

    function automatic box_t mk_box(box_op_t o, int x0, int y0, int z0, int x1, int y1, int z1);
        box_t b;
        b.op = o;
        b.min_x = COORD_BITS'(x0);
        b.min_y = COORD_BITS'(y0);
        b.min_z = COORD_BITS'(z0);
        b.max_x = COORD_BITS'(x1);
        b.max_y = COORD_BITS'(y1);
        b.max_z = COORD_BITS'(z1);
        return b;
    endfunction

    function automatic box_t random_box();
        int lo3 [AXES];
        int hi3 [AXES];
        int sel, ctr, half;
        sel = $urandom_range(0, 9);
        for (int k = 0; k < AXES; k++)
        begin
            if (sel < 8)
            begin
                ctr = int'($urandom_range(0, 8000)) - 4000;
                half = (sel == 0) ? int'($urandom_range(0, 12000)) : int'($urandom_range(0, 1500));
                lo3[k] = ctr - half;
                hi3[k] = ctr + half;
            end
            else
            begin
                lo3[k] = int'($urandom_range(0, 65535)) - 32768;
                hi3[k] = int'($urandom_range(0, 65535)) - 32768;
            end
        end
        return mk_box(box_op_t'($urandom_range(0, 1)), lo3[0], lo3[1], lo3[2],
                      hi3[0], hi3[1], hi3[2]);
    endfunction

    task automatic send_box(box_t b);
        in_valid <= 1'b1;
        op       <= b.op;
        min_x    <= b.min_x;
        min_y    <= b.min_y;
        min_z    <= b.min_z;
        max_x    <= b.max_x;
        max_y    <= b.max_y;
        max_z    <= b.max_z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_status.push_back(classify_box(b));
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic drain();
        if (in_valid)
            in_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(plane_idx_t idx, logic [PLANE_W-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        if (idx < NUM_PLANES)
            plane_copy[idx] = value;
        @(posedge clk);
    endtask

    // Load next_planes, then poke one unmapped index that must be dropped.
    task automatic program_planes();
        for (int p = 0; p < NUM_PLANES; p++)
            write_reg(plane_idx_t'(p), next_planes[p]);
        write_reg($urandom_range(0, 1) ? PL_UNMAPPED_HI : PL_UNMAPPED_LO, {$urandom, $urandom});
        wr_en <= 1'b0;
    endtask

    task automatic random_frustum();
        next_planes[PL_NEAR]   = facing_plane(1, 1'b0);
        next_planes[PL_FAR]    = facing_plane(1, 1'b1);
        next_planes[PL_LEFT]   = facing_plane(0, 1'b0);
        next_planes[PL_RIGHT]  = facing_plane(0, 1'b1);
        next_planes[PL_TOP]    = facing_plane(2, 1'b1);
        next_planes[PL_BOTTOM] = facing_plane(2, 1'b0);
    endtask

    task automatic run_random(int count);
        repeat (count) send_box(random_box());
    endtask

    task automatic apply_reset();
        for (int p = 0; p < NUM_PLANES; p++)
            plane_copy[p] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    task automatic test_reset_planes();
        tx_gaps = 1'b1;
        rx_jitter = 1'b1;
        send_box(mk_box(OP_FULL, -32768, -32768, -32768, 32767, 32767, 32767));
        send_box(mk_box(OP_FLAT, 32767, 32767, 32767, -32768, -32768, -32768));
        send_box(mk_box(OP_FULL, 0, 0, 0, 0, 0, 0));
        drain();
    endtask

    task automatic test_axis_frustum();
        next_planes[PL_NEAR]   = pack_plane(0, ONE_Q14, 0, 1600);
        next_planes[PL_FAR]    = pack_plane(0, -ONE_Q14, 0, 1600);
        next_planes[PL_LEFT]   = pack_plane(ONE_Q14, 0, 0, 1600);
        next_planes[PL_RIGHT]  = pack_plane(-ONE_Q14, 0, 0, 1600);
        next_planes[PL_TOP]    = pack_plane(0, 0, -ONE_Q14, 1600);
        next_planes[PL_BOTTOM] = pack_plane(0, 0, ONE_Q14, 1600);
        program_planes();
        send_box(mk_box(OP_FULL, -160, -160, -160, 160, 160, 160));
        send_box(mk_box(OP_FLAT, -160, -160, -160, 160, 160, 160));
        send_box(mk_box(OP_FULL, -160, -3000, -160, 160, -2000, 160));
        send_box(mk_box(OP_FULL, -160, 2000, -160, 160, 3000, 160));
        send_box(mk_box(OP_FULL, -3000, -160, -160, -2000, 160, 160));
        send_box(mk_box(OP_FULL, 2000, -160, -160, 3000, 160, 160));
        send_box(mk_box(OP_FULL, -160, -160, 2000, 160, 160, 3000));
        send_box(mk_box(OP_FULL, -160, -160, -3000, 160, 160, -2000));
        send_box(mk_box(OP_FLAT, -160, -160, 2000, 160, 160, 3000));
        send_box(mk_box(OP_FLAT, -160, 2000, -160, 160, 3000, 160));
        send_box(mk_box(OP_FULL, -2000, -160, -160, 0, 160, 160));
        send_box(mk_box(OP_FULL, -1600, -160, -160, 0, 160, 160));
        send_box(mk_box(OP_FULL, -3000, -160, -160, -1600, 160, 160));
        send_box(mk_box(OP_FULL, 2000, -160, -160, -2000, 160, 160));
        send_box(mk_box(OP_FULL, -32768, -32768, -32768, 32767, 32767, 32767));
        send_box(mk_box(OP_FLAT, -32768, -32768, -32768, 32767, 32767, 32767));
        drain();
    endtask

    task automatic test_extreme_planes();
        next_planes[PL_NEAR]   = pack_plane(-32768, -32768, -32768, -32768);
        next_planes[PL_FAR]    = pack_plane(32767, 32767, 32767, 32767);
        next_planes[PL_LEFT]   = pack_plane(-32768, 32767, 0, 32767);
        next_planes[PL_RIGHT]  = pack_plane(32767, -32768, -1, 0);
        next_planes[PL_TOP]    = pack_plane(0, 0, 32767, -32768);
        next_planes[PL_BOTTOM] = pack_plane(1, -1, -32768, 1);
        program_planes();
        send_box(mk_box(OP_FULL, -32768, -32768, -32768, -32768, -32768, -32768));
        send_box(mk_box(OP_FULL, 32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(OP_FLAT, -32768, 32767, -32768, 32767, -32768, 32767));
        send_box(mk_box(OP_FULL, -32768, 32767, -32768, 32767, -32768, 32767));
        drain();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            if (phase == 2)
            begin
                for (int p = 0; p < NUM_PLANES; p++)
                    next_planes[p] = {$urandom, $urandom};
            end
            else
                random_frustum();
            program_planes();
            tx_gaps = (phase % 3) != 2;
            rx_jitter = (phase % 3) != 1;
            run_random(PHASE_ITEMS);
        end
        drain();
    endtask

    task automatic test_backpressure();
        tx_gaps = 1'b0;
        rx_jitter = 1'b0;
        random_frustum();
        program_planes();
        hold_requests <= hold_requests + 1;
        run_random(48);
        drain();
    endtask

    task automatic test_steady_stream();
        tx_gaps = 1'b0;
        rx_jitter = 1'b0;
        for (int phase = 0; phase < 2; phase++)
        begin
            random_frustum();
            program_planes();
            run_random(PHASE_ITEMS);
            drain();
        end
    endtask

    initial
    begin : rx_stall
        int burst;
        int holds_served;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_jitter && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 19);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        fcb_status_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_status.size() == 0)
            begin
                $error("status: expected none, got %0d", status);
                mismatches++;
            end
            else
            begin
                want = expected_status.pop_front();
                if (status !== want)
                begin
                    $error("status: expected %0d, got %0d", want, status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        apply_reset();
        test_reset_planes();
        test_axis_frustum();
        test_extreme_planes();
        test_random_traffic();
        test_backpressure();
        test_steady_stream();
        if (expected_status.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
